// ===== rtl/gccc_pkg.sv =====
// Shared types, constants and a helper function of the connected component counter.
package gccc_pkg;

	localparam int MAX_V = 64;
	localparam int VW = $clog2(MAX_V);
	localparam int CNT_W = $clog2(MAX_V + 1);
	localparam int EDGE_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTED_MODE = 1'b1;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_COUNT = 1'b1;

	typedef struct packed {
		logic load;
		logic check;
		logic adj_rd_dst;
		logic adj_wr_src;
		logic adj_wr_dst;
		logic cnt_init;
		logic root;
		logic pop;
		logic row_rd;
		logic row_get;
		logic push;
	} gccc_cmd_t;

	typedef struct packed {
		logic range_err;
		logic directed;
		logic cand_zero;
		logic depth_zero;
		logic pend_zero;
	} gccc_status_t;

	function automatic logic [VW-1:0] first_set(input logic [MAX_V-1:0] m);
		logic [VW-1:0] r;
		r = '0;
		for (int i = MAX_V - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = VW'(i);
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/graph_connected_component_counter.sv =====
// Top level of the connected component counter over a bit adjacency matrix.
//
// A command is transferred when start is high and busy is low. opcode 0 inserts the
// edge (src_vertex, dst_vertex), mirrored unless directed_mode is set; opcode 1
// counts the roots of a depth-first search over vertices below vertex_count.
// Each command gives exactly one result, shown for one cycle with done high:
// component_count, edge_total (saturating) and range_error. The receiver cannot
// stall; the result must be taken in that cycle.
// An insert checks the range; if in range it writes the source row and, unless
// directed, reads and writes the destination row before the result. A count
// clears the search state; each visited vertex then costs a stack pop, an adjacency
// row read, a row capture and a final check for pending neighbors, each root a stack
// write and an empty-stack check, and each newly found neighbor one stack write.
// Configuration writes use cfg_valid and cfg_ready (always high): index 0 sets
// vertex_count, index 1 sets directed_mode; write only while the block is idle.
// Reset clears the matrix at once through per-row valid bits, the edge counter,
// and sets vertex_count to 64 and directed_mode to 0.
module graph_connected_component_counter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               opcode,
	input  logic [gccc_pkg::VW-1:0]            src_vertex,
	input  logic [gccc_pkg::VW-1:0]            dst_vertex,
	output logic                               done,
	output logic [gccc_pkg::CNT_W-1:0]         component_count,
	output logic [gccc_pkg::EDGE_W-1:0]        edge_total,
	output logic                               range_error,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gccc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gccc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	gccc_pkg::gccc_cmd_t    cmd;
	gccc_pkg::gccc_status_t status;

	assign cfg_ready = 1'b1;

	gccc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gccc_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_valid & cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.opcode          (opcode),
		.src_vertex      (src_vertex),
		.dst_vertex      (dst_vertex),
		.component_count (component_count),
		.edge_total      (edge_total),
		.range_error     (range_error)
	);

endmodule

// ===== rtl/gccc_ram.sv =====
// Generic single write port RAM with one registered read port.
module gccc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/gccc_datapath.sv =====
// Datapath: adjacency matrix, search stack, visited mask, counters and configuration.
module gccc_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gccc_pkg::gccc_cmd_t                cmd,
	output gccc_pkg::gccc_status_t             status,
	input  logic                               cfg_we,
	input  logic [gccc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gccc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               opcode,
	input  logic [gccc_pkg::VW-1:0]            src_vertex,
	input  logic [gccc_pkg::VW-1:0]            dst_vertex,
	output logic [gccc_pkg::CNT_W-1:0]         component_count,
	output logic [gccc_pkg::EDGE_W-1:0]        edge_total,
	output logic                               range_error
);

	logic [gccc_pkg::CFG_DATA_W-1:0] vcount_q;
	logic                            directed_q;
	logic                            op_q;
	logic [gccc_pkg::VW-1:0]         src_q;
	logic [gccc_pkg::VW-1:0]         dst_q;
	logic                            err_q;
	logic [gccc_pkg::EDGE_W-1:0]     edges_q;
	logic [gccc_pkg::MAX_V-1:0]      row_valid_q;
	logic                            rowv_q;
	logic [gccc_pkg::MAX_V-1:0]      visited_q;
	logic [gccc_pkg::MAX_V-1:0]      pend_q;
	logic [gccc_pkg::CNT_W-1:0]      depth_q;
	logic [gccc_pkg::CNT_W-1:0]      roots_q;

	logic [gccc_pkg::CNT_W-1:0]      n_eff;
	logic [gccc_pkg::MAX_V-1:0]      nmask;
	logic [gccc_pkg::MAX_V-1:0]      cand;
	logic [gccc_pkg::MAX_V-1:0]      row_data;
	logic [gccc_pkg::MAX_V-1:0]      fresh;
	logic [gccc_pkg::VW-1:0]         cand_first;
	logic [gccc_pkg::VW-1:0]         pend_first;
	logic [gccc_pkg::CNT_W-1:0]      depth_dec;
	logic                            range_err;

	logic                            adj_we;
	logic [gccc_pkg::VW-1:0]         adj_waddr;
	logic [gccc_pkg::MAX_V-1:0]      adj_wdata;
	logic [gccc_pkg::VW-1:0]         adj_raddr;
	logic [gccc_pkg::MAX_V-1:0]      adj_rdata;
	logic [gccc_pkg::VW-1:0]         set_bit;

	logic                            stk_we;
	logic [gccc_pkg::VW-1:0]         stk_wdata;
	logic [gccc_pkg::VW-1:0]         stk_rdata;

	assign n_eff = (vcount_q > gccc_pkg::CNT_W'(gccc_pkg::MAX_V)) ?
		gccc_pkg::CNT_W'(gccc_pkg::MAX_V) : gccc_pkg::CNT_W'(vcount_q);

	always_comb begin
		for (int i = 0; i < gccc_pkg::MAX_V; i++) begin
			nmask[i] = gccc_pkg::CNT_W'(i) < n_eff;
		end
	end

	assign range_err = (gccc_pkg::CNT_W'(src_q) >= n_eff) ||
		(gccc_pkg::CNT_W'(dst_q) >= n_eff);
	assign cand = ~visited_q & nmask;
	assign row_data = rowv_q ? adj_rdata : '0;
	assign fresh = row_data & ~visited_q & nmask;
	assign cand_first = gccc_pkg::first_set(cand);
	assign pend_first = gccc_pkg::first_set(pend_q);
	assign depth_dec = depth_q - 1'b1;

	// Adjacency matrix access: rows are read, a bit is set, and the row is written back.
	always_comb begin
		if (cmd.row_rd) begin
			adj_raddr = stk_rdata;
		end else if (cmd.adj_rd_dst) begin
			adj_raddr = dst_q;
		end else begin
			adj_raddr = src_q;
		end
	end

	assign adj_we = cmd.adj_wr_src | cmd.adj_wr_dst;
	assign adj_waddr = cmd.adj_wr_dst ? dst_q : src_q;
	assign set_bit = cmd.adj_wr_dst ? src_q : dst_q;
	assign adj_wdata = row_data | (gccc_pkg::MAX_V'(1) << set_bit);

	gccc_ram #(
		.WIDTH(gccc_pkg::MAX_V),
		.DEPTH(gccc_pkg::MAX_V)
	) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	assign stk_we = cmd.root | cmd.push;
	assign stk_wdata = cmd.root ? cand_first : pend_first;

	gccc_ram #(
		.WIDTH(gccc_pkg::VW),
		.DEPTH(gccc_pkg::MAX_V)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (depth_q[gccc_pkg::VW-1:0]),
		.wdata (stk_wdata),
		.raddr (depth_dec[gccc_pkg::VW-1:0]),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			src_q <= src_vertex;
			dst_q <= dst_vertex;
		end
		if (cmd.row_get) begin
			pend_q <= fresh;
		end else if (cmd.push) begin
			pend_q <= pend_q & ~(gccc_pkg::MAX_V'(1) << pend_first);
		end
		if (cmd.cnt_init) begin
			visited_q <= '0;
		end else if (cmd.root) begin
			visited_q <= visited_q | (gccc_pkg::MAX_V'(1) << cand_first);
		end else if (cmd.row_get) begin
			visited_q <= visited_q | fresh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= gccc_pkg::CFG_DATA_W'(gccc_pkg::MAX_V);
			directed_q <= 1'b0;
			err_q <= 1'b0;
			edges_q <= '0;
			row_valid_q <= '0;
			rowv_q <= 1'b0;
			depth_q <= '0;
			roots_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gccc_pkg::REG_VERTEX_COUNT: vcount_q <= cfg_data;
					gccc_pkg::REG_DIRECTED_MODE: directed_q <= cfg_data[0];
					default: ;
				endcase
			end
			rowv_q <= row_valid_q[adj_raddr];
			if (adj_we) begin
				row_valid_q[adj_waddr] <= 1'b1;
			end
			if (cmd.load) begin
				err_q <= 1'b0;
			end else if (cmd.check) begin
				err_q <= range_err;
				if (!range_err && edges_q != '1) begin
					edges_q <= edges_q + 1'b1;
				end
			end
			if (cmd.cnt_init) begin
				depth_q <= '0;
				roots_q <= '0;
			end else begin
				if (cmd.root) begin
					roots_q <= roots_q + 1'b1;
				end
				if (stk_we) begin
					depth_q <= depth_q + 1'b1;
				end else if (cmd.pop) begin
					depth_q <= depth_dec;
				end
			end
		end
	end

	assign status.range_err = range_err;
	assign status.directed = directed_q;
	assign status.cand_zero = cand == '0;
	assign status.depth_zero = depth_q == '0;
	assign status.pend_zero = pend_q == '0;

	assign component_count = (op_q == gccc_pkg::OP_COUNT) ? roots_q : '0;
	assign edge_total = edges_q;
	assign range_error = err_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= gccc_pkg::CNT_W'(gccc_pkg::MAX_V))
		else $error("Search stack depth exceeds the vertex limit.");

	a_push_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> pend_q != '0)
		else $error("Push issued with no pending neighbor.");

	a_root_unvisited: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.root |=> roots_q <= n_eff)
		else $error("More search roots than vertices in use.");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> depth_q != '0)
		else $error("Pop issued on an empty search stack.");

endmodule

// ===== rtl/gccc_ctrl.sv =====
// Controller state machine that sequences edge inserts and the depth-first search.
module gccc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   opcode,
	input  gccc_pkg::gccc_status_t status,
	output gccc_pkg::gccc_cmd_t    cmd,
	output logic                   busy,
	output logic                   done
);

	typedef enum logic [11:0] {
		S_IDLE    = 12'b000000000001,
		S_I_CHECK = 12'b000000000010,
		S_I_WR1   = 12'b000000000100,
		S_I_RD2   = 12'b000000001000,
		S_I_WR2   = 12'b000000010000,
		S_C_INIT  = 12'b000000100000,
		S_C_ROOT  = 12'b000001000000,
		S_C_POP   = 12'b000010000000,
		S_C_ROWRD = 12'b000100000000,
		S_C_ROWGT = 12'b001000000000,
		S_C_PUSH  = 12'b010000000000,
		S_RESULT  = 12'b100000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = (opcode == gccc_pkg::OP_INSERT) ? S_I_CHECK : S_C_INIT;
				end
			end
			S_I_CHECK: begin
				cmd.check = 1'b1;
				state_d = status.range_err ? S_RESULT : S_I_WR1;
			end
			S_I_WR1: begin
				cmd.adj_wr_src = 1'b1;
				state_d = status.directed ? S_RESULT : S_I_RD2;
			end
			S_I_RD2: begin
				cmd.adj_rd_dst = 1'b1;
				state_d = S_I_WR2;
			end
			S_I_WR2: begin
				cmd.adj_wr_dst = 1'b1;
				state_d = S_RESULT;
			end
			S_C_INIT: begin
				cmd.cnt_init = 1'b1;
				state_d = S_C_ROOT;
			end
			S_C_ROOT: begin
				if (status.cand_zero) begin
					state_d = S_RESULT;
				end else begin
					cmd.root = 1'b1;
					state_d = S_C_POP;
				end
			end
			S_C_POP: begin
				if (status.depth_zero) begin
					state_d = S_C_ROOT;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_C_ROWRD;
				end
			end
			S_C_ROWRD: begin
				cmd.row_rd = 1'b1;
				state_d = S_C_ROWGT;
			end
			S_C_ROWGT: begin
				cmd.row_get = 1'b1;
				state_d = S_C_PUSH;
			end
			S_C_PUSH: begin
				if (status.pend_zero) begin
					state_d = S_C_POP;
				end else begin
					cmd.push = 1'b1;
				end
			end
			S_RESULT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_RESULT;

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("Controller did not return to idle after a result.");

	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("Accepted command did not make the block busy.");

	a_insert_check_first: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == gccc_pkg::OP_INSERT) |=> state_q == S_I_CHECK)
		else $error("Insert did not begin with the range check.");

endmodule

// ===== verif/graph_connected_component_counter_tb.sv =====
// Self-checking testbench for the connected component counter with a built-in graph predictor.
module graph_connected_component_counter_tb;

	typedef struct {
		logic                    op;
		logic [gccc_pkg::VW-1:0] src;
		logic [gccc_pkg::VW-1:0] dst;
		bit                      drain_first;
	} graph_cmd_t;

	typedef struct {
		logic [gccc_pkg::CNT_W-1:0]  roots;
		logic [gccc_pkg::EDGE_W-1:0] edges;
		logic                        range_err;
	} graph_answer_t;

	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int SETTLE_CYCLES = 1000;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            start = 1'b0;
	logic                            busy;
	logic                            opcode = gccc_pkg::OP_INSERT;
	logic [gccc_pkg::VW-1:0]         src_vertex = '0;
	logic [gccc_pkg::VW-1:0]         dst_vertex = '0;
	logic                            done;
	logic [gccc_pkg::CNT_W-1:0]      component_count;
	logic [gccc_pkg::EDGE_W-1:0]     edge_total;
	logic                            range_error;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [gccc_pkg::CFG_IDX_W-1:0]  cfg_index = gccc_pkg::REG_VERTEX_COUNT;
	logic [gccc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [gccc_pkg::MAX_V-1:0]      adj_model [gccc_pkg::MAX_V];
	logic [gccc_pkg::CFG_DATA_W-1:0] vertex_count_model =
		gccc_pkg::CFG_DATA_W'(gccc_pkg::MAX_V);
	logic                            directed_model = 1'b0;
	logic [gccc_pkg::EDGE_W-1:0]     edge_count_model = '0;

	graph_cmd_t    pending_cmds[$];
	graph_answer_t expected_answers[$];
	graph_cmd_t    cur_cmd;
	graph_answer_t exp_answer;
	int            sent_items = 0;
	int            mismatches = 0;
	int            cycle_count = 0;
	bit            quiet;
	bit            hold_off;

	graph_connected_component_counter i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.src_vertex      (src_vertex),
		.dst_vertex      (dst_vertex),
		.done            (done),
		.component_count (component_count),
		.edge_total      (edge_total),
		.range_error     (range_error),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned active_vertices();
		return (vertex_count_model > gccc_pkg::MAX_V) ? gccc_pkg::MAX_V : vertex_count_model;
	endfunction

	function automatic graph_answer_t apply_graph_cmd(graph_cmd_t c);
		graph_answer_t              a;
		int unsigned                n;
		logic [gccc_pkg::MAX_V-1:0] in_use;
		logic [gccc_pkg::MAX_V-1:0] seen;
		logic [gccc_pkg::MAX_V-1:0] reach;
		logic [gccc_pkg::MAX_V-1:0] grown;
		n = active_vertices();
		a.roots = '0;
		a.range_err = 1'b0;
		in_use = '0;
		for (int i = 0; i < n; i++) begin
			in_use[i] = 1'b1;
		end
		if (c.op == gccc_pkg::OP_INSERT) begin
			if (c.src >= n || c.dst >= n) begin
				a.range_err = 1'b1;
			end else begin
				if (edge_count_model != '1) begin
					edge_count_model = edge_count_model + 1'b1;
				end
				adj_model[c.src][c.dst] = 1'b1;
				if (!directed_model) begin
					adj_model[c.dst][c.src] = 1'b1;
				end
			end
		end else begin
			seen = '0;
			for (int r = 0; r < n; r++) begin
				if (!seen[r]) begin
					a.roots = a.roots + 1'b1;
					grown = '0;
					grown[r] = 1'b1;
					do begin
						reach = grown;
						for (int v = 0; v < n; v++) begin
							if (reach[v]) begin
								grown = grown | (adj_model[v] & in_use & ~seen);
							end
						end
					end while (grown != reach);
					seen = seen | reach;
				end
			end
		end
		a.edges = edge_count_model;
		return a;
	endfunction

	task automatic add_cmd(logic op, int unsigned src, int unsigned dst, bit drain = 1'b0);
		graph_cmd_t c;
		c.op = op;
		c.src = gccc_pkg::VW'(src);
		c.dst = gccc_pkg::VW'(dst);
		c.drain_first = drain;
		pending_cmds.push_back(c);
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_cmds.size() != 0 || expected_answers.size() != 0 || start || busy);
	endtask

	task automatic write_reg(logic [gccc_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= gccc_pkg::CFG_DATA_W'(val);
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_random_cmds(int unsigned total);
		int unsigned n;
		int unsigned added;
		int unsigned kind;
		int unsigned burst;
		int unsigned base;
		int unsigned top;
		n = active_vertices();
		added = 0;
		while (added < total) begin
			kind = $urandom_range(99);
			if (kind < 75) begin
				// A small burst of edges inside one vertex window, then a count.
				burst = $urandom_range(8, 1);
				base = (n > 0) ? $urandom_range(n - 1) : 0;
				top = (n > 0) ? base + $urandom_range(7) : 63;
				if (n > 0 && top > n - 1) begin
					top = n - 1;
				end
				repeat (burst) begin
					add_cmd(gccc_pkg::OP_INSERT, $urandom_range(top, base),
						$urandom_range(top, base));
				end
				add_cmd(gccc_pkg::OP_COUNT, $urandom_range(63), $urandom_range(63),
					$urandom_range(19) == 0);
				added += burst + 1;
			end else if (kind < 90) begin
				burst = $urandom_range(3, 1);
				repeat (burst) begin
					add_cmd(gccc_pkg::OP_INSERT, $urandom_range(63), $urandom_range(63));
				end
				added += burst;
			end else begin
				add_cmd(gccc_pkg::OP_COUNT, $urandom_range(63), $urandom_range(63),
					$urandom_range(3) == 0);
				added++;
			end
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_answers.push_back(apply_graph_cmd(cur_cmd));
				sent_items++;
			end
			if (!start || !busy) begin
				quiet = (sent_items >= 300 && sent_items < 550);
				hold_off = (!quiet && $urandom_range(99) < 12);
				if (pending_cmds.size() != 0 && pending_cmds[0].drain_first
						&& expected_answers.size() != 0) begin
					hold_off = 1'b1;
				end
				if (pending_cmds.size() != 0 && !hold_off) begin
					cur_cmd = pending_cmds.pop_front();
					start <= 1'b1;
					opcode <= cur_cmd.op;
					src_vertex <= cur_cmd.src;
					dst_vertex <= cur_cmd.dst;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				if (mismatches < 10) begin
					$display("unexpected result: count %0d edges %0d range_error %0b",
						component_count, edge_total, range_error);
				end
				mismatches++;
			end else begin
				exp_answer = expected_answers.pop_front();
				if (component_count !== exp_answer.roots || edge_total !== exp_answer.edges
						|| range_error !== exp_answer.range_err) begin
					if (mismatches < 10) begin
						$display({"mismatch: count %0d/%0d edges %0d/%0d ",
							"range_error %0b/%0b (expected/actual)"},
							exp_answer.roots, component_count, exp_answer.edges, edge_total,
							exp_answer.range_err, range_error);
					end
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				gccc_pkg::REG_VERTEX_COUNT: begin
					vertex_count_model = cfg_data;
				end
				gccc_pkg::REG_DIRECTED_MODE: begin
					directed_model = cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	initial begin
		int unsigned vc_choice [12];
		vc_choice = '{8, 64, 16, 3, 127, 32, 1, 48, 0, 24, 64, 100};
		for (int i = 0; i < gccc_pkg::MAX_V; i++) begin
			adj_model[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		add_cmd(gccc_pkg::OP_COUNT, 0, 0);
		add_cmd(gccc_pkg::OP_INSERT, 0, 63);
		add_cmd(gccc_pkg::OP_INSERT, 63, 0);
		add_cmd(gccc_pkg::OP_COUNT, 63, 63, 1'b1);
		add_cmd(gccc_pkg::OP_INSERT, 63, 63);
		add_cmd(gccc_pkg::OP_INSERT, 62, 61);
		add_cmd(gccc_pkg::OP_COUNT, 0, 0);
		wait_idle();
		write_reg(gccc_pkg::REG_VERTEX_COUNT, 0);
		add_cmd(gccc_pkg::OP_INSERT, 0, 0);
		add_cmd(gccc_pkg::OP_COUNT, 0, 0);
		wait_idle();
		write_reg(gccc_pkg::REG_VERTEX_COUNT, 1);
		add_cmd(gccc_pkg::OP_INSERT, 0, 1);
		add_cmd(gccc_pkg::OP_INSERT, 1, 0);
		add_cmd(gccc_pkg::OP_INSERT, 0, 0);
		add_cmd(gccc_pkg::OP_COUNT, 0, 0);
		wait_idle();
		write_reg(gccc_pkg::REG_VERTEX_COUNT, 127);
		write_reg(gccc_pkg::REG_DIRECTED_MODE, 1);
		add_cmd(gccc_pkg::OP_INSERT, 63, 62);
		add_cmd(gccc_pkg::OP_INSERT, 10, 11);
		add_cmd(gccc_pkg::OP_INSERT, 12, 10);
		add_cmd(gccc_pkg::OP_COUNT, 0, 0);
		wait_idle();
		write_reg(gccc_pkg::REG_VERTEX_COUNT, 2);
		add_cmd(gccc_pkg::OP_COUNT, 0, 0);
		add_cmd(gccc_pkg::OP_INSERT, 1, 0);
		add_cmd(gccc_pkg::OP_COUNT, 0, 0);
		add_cmd(gccc_pkg::OP_INSERT, 63, 0);
		wait_idle();

		foreach (vc_choice[p]) begin
			write_reg(gccc_pkg::REG_VERTEX_COUNT, vc_choice[p]);
			write_reg(gccc_pkg::REG_DIRECTED_MODE, $urandom_range(1));
			add_random_cmds(100);
			wait_idle();
		end

		write_reg(gccc_pkg::REG_DIRECTED_MODE, 1);
		write_reg(gccc_pkg::REG_VERTEX_COUNT, 10);
		add_cmd(gccc_pkg::OP_INSERT, 20, 1);
		add_cmd(gccc_pkg::OP_INSERT, 1, 2);
		add_cmd(gccc_pkg::OP_COUNT, 0, 0);
		wait_idle();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_answers.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
